// ===== rtl/core/ising_pkg.sv =====
`default_nettype none
package ising_pkg;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = 1 << ADDR_W;
  localparam int MAX_ROWS = 1 << ROW_W;
  localparam int MAX_COLS = 1 << COL_W;
  localparam int SIZE_W = 7;
  localparam int DE_W = 16;
  localparam int DIV_W = 32;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_STEP = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] CFG_ROWS = 3'd0;
  localparam logic [2:0] CFG_COLS = 3'd1;
  localparam logic [2:0] CFG_COUPLING = 3'd2;
  localparam logic [2:0] CFG_FIELD = 3'd3;
  localparam logic [2:0] CFG_TEMP = 3'd4;

  typedef struct packed {
    logic [DE_W-1:0] de;
    logic [15:0] t;
  } acc_req_t;

  function automatic logic [16:0] exp2_tab(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ising_accept.sv =====
`default_nettype none
module ising_accept
  import ising_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire acc_req_t    req,
  output logic             done,
  output logic [16:0]      thresh
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_INT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r;
  logic [DIV_W-1:0] num_r;
  logic [16:0] rem_r;
  logic [15:0] t_r;
  logic [53:0] y_r;
  logic [16:0] m_r;
  logic [16:0] rem_sh;
  logic [16:0] diff;
  logic [28:0] dprod;
  logic [4:0] k;
  logic [37:0] y_hi;

  assign rem_sh = {rem_r[15:0], num_r[DIV_W-1]};
  assign k = {1'b0, y_r[15:12]};
  assign diff = exp2_tab(k) - exp2_tab(k + 5'd1);
  assign dprod = diff * {17'd0, y_r[11:0]};
  assign y_hi = y_r[53:16];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DIV;
      S_DIV: if (cnt_r == 6'd31) state_nxt = S_MUL;
      S_MUL: state_nxt = S_INT;
      S_INT: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        num_r <= {req.de, 16'd0};
        rem_r <= '0;
        t_r <= (req.t == 16'd0) ? 16'd1 : req.t;
        cnt_r <= '0;
      end
      S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (rem_sh >= {1'b0, t_r}) begin
          rem_r <= rem_sh - {1'b0, t_r};
          num_r <= {num_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[DIV_W-2:0], 1'b0};
        end
      end
      S_MUL: y_r <= {22'd0, num_r} * {37'd0, LOG2E_Q16} >> 16;
      S_INT: m_r <= exp2_tab(k) - dprod[28:12];
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == S_OUT);
  assign thresh = (y_hi > 38'd16) ? 17'd0 : (m_r >> y_hi[4:0]);
endmodule
`default_nettype wire

// ===== rtl/core/ising_metropolis_spin_update_unit.sv =====
// One item is handled at a time. A write, an ignored action or an out-of-range coordinate
// finishes straight from the read state; a read also waits for the registered read data.
// A step reads the center and its four neighbors from the spin memory, one
// address per cycle; with a negative dE the spin flips without an acceptance test,
// otherwise a bit-serial Q16 division by T and the exponential decide the flip.
// The result waits in an output register and the next item is taken the cycle after it
// has left. Spins are undefined until written.
`default_nettype none
module ising_metropolis_spin_update_unit
  import ising_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[1:0], row[7:2], col[13:8], spin_in[14], random_value[30:15], zero pad
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // spin_out[0], flipped[1], energy_change[17:2], coord_error[18], zero pad
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;
  localparam logic [3:0] S_NB = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_ACC = 4'd4;
  localparam logic [3:0] S_WB = 4'd5;
  localparam logic [3:0] S_OUT = 4'd6;

  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [11:0] coup_r, field_r;
  logic [15:0] temp_r;
  logic [3:0] state_r;
  logic [1:0] act_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic sin_r;
  logic [15:0] rnd_r;
  logic [2:0] rd_cnt_r;
  logic [2:0] sum_r;
  logic centre_r;
  logic [DE_W-1:0] de_r;
  logic flip_r;
  logic spin_mem [DEPTH];
  logic rdata_r;
  logic [ADDR_W-1:0] raddr;
  logic we;
  logic wbit;
  logic [SIZE_W-1:0] nr, nc;
  logic [ROW_W-1:0] up, dn, rr;
  logic [COL_W-1:0] rt, lf, cc;
  logic bad;
  logic [16:0] thresh;
  logic acc_done;
  acc_req_t acc_req;
  logic [18:0] res_r;
  logic out_v_r;
  logic signed [3:0] ssum;
  logic signed [17:0] jsum;
  logic signed [19:0] de_full;
  logic [ROW_W:0] row_x;
  logic [COL_W:0] col_x;

  always_comb begin
    nr = (rows_r < 7'd2) ? 7'd2 : (rows_r > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_r;
    nc = (cols_r < 7'd2) ? 7'd2 : (cols_r > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_r;
    row_x = {1'b0, row_r};
    col_x = {1'b0, col_r};
    bad = (row_x >= nr) || (col_x >= nc);
    up = (row_x + 7'd1 == nr) ? '0 : row_r + 6'd1;
    dn = (row_r == '0) ? ROW_W'(nr - 7'd1) : row_r - 6'd1;
    rt = (col_x + 7'd1 == nc) ? '0 : col_r + 6'd1;
    lf = (col_r == '0) ? COL_W'(nc - 7'd1) : col_r - 6'd1;
    rr = row_r;
    cc = col_r;
    unique case (rd_cnt_r)
      3'd1: rr = up;
      3'd2: rr = dn;
      3'd3: cc = rt;
      3'd4: cc = lf;
      default: begin
      end
    endcase
    raddr = {rr, cc};
    ssum = 4'(signed'({1'b0, sum_r})) * 4'sd2 - 4'sd4;
    jsum = signed'(coup_r) * ssum;
    de_full = 20'(jsum) - 20'(signed'(field_r));
    de_full = centre_r ? de_full <<< 1 : -(de_full <<< 1);
  end

  assign we = (state_r == S_RD && act_r == ACT_WRITE && !bad) || (state_r == S_WB && flip_r);
  assign wbit = (state_r == S_RD) ? sin_r : ~centre_r;

  always_ff @(posedge clk) begin
    if (we) spin_mem[{row_r, col_r}] <= wbit;
    rdata_r <= spin_mem[raddr];
  end

  assign acc_req.de = de_r;
  assign acc_req.t = temp_r;

  ising_accept u_acc (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_ACC && !acc_done && rd_cnt_r == 3'd0),
    .req(acc_req), .done(acc_done), .thresh(thresh)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd64;
      cols_r <= 7'd64;
      coup_r <= 12'd256;
      field_r <= 12'd0;
      temp_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data[6:0];
        CFG_COLS: cols_r <= cfg_data[6:0];
        CFG_COUPLING: coup_r <= cfg_data[11:0];
        CFG_FIELD: field_r <= cfg_data[11:0];
        CFG_TEMP: temp_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && !out_v_r) begin
          act_r <= in_tdata[1:0];
          row_r <= in_tdata[7:2];
          col_r <= in_tdata[13:8];
          sin_r <= in_tdata[14];
          rnd_r <= in_tdata[30:15];
          rd_cnt_r <= '0;
          sum_r <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          if (act_r == ACT_NONE) begin
            res_r <= '0;
            state_r <= S_OUT;
          end else if (bad) begin
            res_r <= {1'b1, 18'd0};
            state_r <= S_OUT;
          end else if (act_r == ACT_WRITE) begin
            res_r <= {18'd0, sin_r};
            state_r <= S_OUT;
          end else begin
            rd_cnt_r <= 3'd1;
            state_r <= S_NB;
          end
        end
        S_NB: begin
          if (rd_cnt_r == 3'd1) begin
            centre_r <= rdata_r;
            if (act_r == ACT_READ) begin
              res_r <= {18'd0, rdata_r};
              state_r <= S_OUT;
            end
          end else begin
            sum_r <= sum_r + {2'd0, rdata_r};
          end
          if (rd_cnt_r == 3'd5) begin
            state_r <= S_CALC;
            rd_cnt_r <= '0;
          end else if (!(rd_cnt_r == 3'd1 && act_r == ACT_READ)) begin
            rd_cnt_r <= rd_cnt_r + 3'd1;
          end
        end
        S_CALC: begin
          de_r <= de_full[15:0];
          if (de_full[19]) begin
            flip_r <= 1'b1;
            state_r <= S_WB;
          end else begin
            state_r <= S_ACC;
          end
        end
        S_ACC: if (acc_done) begin
          flip_r <= ({1'b0, rnd_r} < thresh);
          state_r <= S_WB;
        end
        S_WB: begin
          res_r <= {1'b0, de_r, flip_r, centre_r ^ flip_r};
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = {5'd0, res_r};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[18]) |-> (out_tdata[17:0] == 18'd0)) else $error("error result");
endmodule
`default_nettype wire
